[hw/rtl/periodic_pair_distance_histogram_unit_assert.svh]
`ifndef PERIODIC_PAIR_DISTANCE_HISTOGRAM_UNIT_ASSERT_SVH
`define PERIODIC_PAIR_DISTANCE_HISTOGRAM_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk with reset masked.
`define PPHD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk with reset masked.
`define PPHD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pphd_pkg.sv]
package pphd_pkg;

    localparam int COORD_BITS   = 16;
    localparam int BOX_BITS     = 16;
    localparam int BINS         = 256;
    localparam int MAX_PARTNERS = 4;

    localparam int AX_BITS    = ((COORD_BITS > BOX_BITS) ? COORD_BITS : BOX_BITS) + 1;
    localparam int DELTA_BITS = AX_BITS - 1;
    localparam int SQ_BITS    = 2 * DELTA_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int ROOT_BITS  = SUM_BITS / 2;
    localparam int BIN_BITS   = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int PCNT_BITS  = $clog2(MAX_PARTNERS + 1);

    localparam int CUTOFF_BITS = 18;
    localparam int SCALE_BITS  = 24;
    localparam int BINUSE_BITS = 9;
    localparam int DIST_BITS   = 18;
    localparam int HIT_BITS    = 8;
    localparam int CNT_BITS    = 32;
    localparam int RBIN_BITS   = 8;
    localparam int SCALE_SHIFT = 16;
    localparam int SCALED_BITS = ROOT_BITS + SCALE_BITS;
    localparam int BIDX_BITS   = SCALED_BITS - SCALE_SHIFT;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam int QDEPTH        = 2;
    localparam int QPTR_BITS     = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_X     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_Y     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_Z     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CUTOFF    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BIN_SCALE = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BINS_USED = 3'd5;

    typedef enum logic [1:0] {
        CMD_PAIR  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [BOX_BITS-1:0]    box_x;
        logic [BOX_BITS-1:0]    box_y;
        logic [BOX_BITS-1:0]    box_z;
        logic [CUTOFF_BITS-1:0] cutoff;
        logic [SCALE_BITS-1:0]  bin_scale;
        logic [BINUSE_BITS-1:0] bins_in_use;
    } pphd_cfg_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic                  new_center;
        logic [DELTA_BITS-1:0] dx;
        logic [DELTA_BITS-1:0] dy;
        logic [DELTA_BITS-1:0] dz;
        logic [RBIN_BITS-1:0]  read_bin;
    } pphd_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pphd_qstat_t;

    function automatic logic [DELTA_BITS-1:0] min_image(
        input logic [COORD_BITS-1:0] c,
        input logic [COORD_BITS-1:0] p,
        input logic [BOX_BITS-1:0]   box
    );
        logic [COORD_BITS-1:0] mag;
        logic [AX_BITS-1:0]    mag_e;
        logic [AX_BITS-1:0]    box_e;
        logic [AX_BITS-1:0]    res;
        mag   = (c >= p) ? (c - p) : (p - c);
        mag_e = AX_BITS'(mag);
        box_e = AX_BITS'(box);
        if ((box != '0) && ((mag_e << 1) >= box_e)) begin
            res = (mag_e >= box_e) ? (mag_e - box_e) : (box_e - mag_e);
        end
        else begin
            res = mag_e;
        end
        return res[DELTA_BITS-1:0];
    endfunction

endpackage

[hw/rtl/pphd_front.sv]
module pphd_front
    import pphd_pkg::*;
(
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            command,
    input  logic                  new_center,
    input  logic [15:0]           center_x,
    input  logic [15:0]           center_y,
    input  logic [15:0]           center_z,
    input  logic [15:0]           partner_x,
    input  logic [15:0]           partner_y,
    input  logic [15:0]           partner_z,
    input  logic [RBIN_BITS-1:0]  read_bin,
    input  pphd_cfg_t             cfg,
    input  pphd_qstat_t           qstat,
    output logic                  push,
    output pphd_item_t            item
);

    assign in_stall = qstat.full;
    assign push     = in_valid && !qstat.full;

    always_comb
    begin
        item.cmd        = cmd_t'(command);
        item.new_center = new_center;
        item.dx         = min_image(COORD_BITS'(center_x), COORD_BITS'(partner_x), cfg.box_x);
        item.dy         = min_image(COORD_BITS'(center_y), COORD_BITS'(partner_y), cfg.box_y);
        item.dz         = min_image(COORD_BITS'(center_z), COORD_BITS'(partner_z), cfg.box_z);
        item.read_bin   = read_bin;
    end

endmodule

[hw/rtl/pphd_queue.sv]
module pphd_queue
    import pphd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  pphd_item_t  push_item,
    input  logic        pop,
    output pphd_item_t  head,
    output pphd_qstat_t qstat
);

    pphd_item_t             entry_reg [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QPTR_BITS:0]     count_reg;

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == (QPTR_BITS + 1)'(QDEPTH));
    assign qstat.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hw/rtl/pphd_back.sv]
`include "periodic_pair_distance_histogram_unit_assert.svh"

module pphd_back
    import pphd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pphd_cfg_t             cfg,
    input  pphd_item_t            q_item,
    input  pphd_qstat_t           qstat,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DIST_BITS-1:0]  distance,
    output logic                  counted,
    output logic [HIT_BITS-1:0]   bin_hit,
    output logic                  out_of_range,
    output logic [CNT_BITS-1:0]   bin_count
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SQ    = 8'b0000_0010,
        S_ROOT  = 8'b0000_0100,
        S_BIN   = 8'b0000_1000,
        S_DEC   = 8'b0001_0000,
        S_RDCMD = 8'b0010_0000,
        S_INC   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    localparam logic [SUM_BITS-1:0] BIT_START = SUM_BITS'(1) << (SUM_BITS - 2);

    state_t                  state_reg;
    pphd_item_t              item_reg;
    logic [1:0]              sq_cnt_reg;
    logic [SQ_BITS-1:0]      prod_reg;
    logic [SUM_BITS-1:0]     v_reg;
    logic [SUM_BITS-1:0]     root_reg;
    logic [SUM_BITS-1:0]     bit_reg;
    logic [SCALED_BITS-1:0]  scaled_reg;
    logic                    below_reg;
    logic                    rdok_reg;
    logic [PCNT_BITS-1:0]    pcnt_reg;
    logic [BIN_BITS-1:0]     bin_reg;
    logic [BINS-1:0]         valid_bits_reg;
    logic [CNT_BITS-1:0]     hist_mem [BINS];
    logic [CNT_BITS-1:0]     rd_data_reg;
    logic                    rd_valid_reg;

    logic [DIST_BITS-1:0]    res_dist_reg;
    logic                    res_counted_reg;
    logic [HIT_BITS-1:0]     res_hit_reg;
    logic                    res_oor_reg;
    logic [CNT_BITS-1:0]     res_cnt_reg;

    logic                    out_valid_reg;
    logic [DIST_BITS-1:0]    out_dist_reg;
    logic                    out_counted_reg;
    logic [HIT_BITS-1:0]     out_hit_reg;
    logic                    out_oor_reg;
    logic [CNT_BITS-1:0]     out_cnt_reg;

    logic [DELTA_BITS-1:0]   sel_delta;
    logic [SQ_BITS-1:0]      sq;
    logic [SUM_BITS-1:0]     trial;
    logic                    ge;
    logic [ROOT_BITS-1:0]    root_w;
    logic [BIDX_BITS-1:0]    bin_idx;
    logic [BIDX_BITS-1:0]    lim;
    logic                    slots_full;
    logic                    bin_ok;
    logic                    do_inc;
    logic [CNT_BITS-1:0]     inc_old;
    logic [CNT_BITS-1:0]     inc_new;
    logic                    read_ok;
    logic                    out_free;
    logic                    rd_en;
    logic [BIN_BITS-1:0]     rd_addr;

    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:    sel_delta = item_reg.dx;
            2'd1:    sel_delta = item_reg.dy;
            default: sel_delta = item_reg.dz;
        endcase
    end

    assign sq         = SQ_BITS'(sel_delta) * SQ_BITS'(sel_delta);
    assign trial      = root_reg + bit_reg;
    assign ge         = (v_reg >= trial);
    assign root_w     = root_reg[ROOT_BITS-1:0];
    assign bin_idx    = scaled_reg[SCALED_BITS-1:SCALE_SHIFT];
    assign lim        = (int'(cfg.bins_in_use) > BINS) ? BIDX_BITS'(BINS)
                                                      : BIDX_BITS'(cfg.bins_in_use);
    assign slots_full = (pcnt_reg >= PCNT_BITS'(MAX_PARTNERS));
    assign bin_ok     = (bin_idx < lim);
    assign do_inc     = below_reg && !slots_full && bin_ok;
    assign inc_old    = rd_valid_reg ? rd_data_reg : '0;
    assign inc_new    = (inc_old == '1) ? inc_old : (inc_old + 1'b1);
    assign read_ok    = (int'(q_item.read_bin) < BINS);
    assign out_free   = !out_valid_reg || !out_stall;
    assign q_pop      = (state_reg == S_IDLE) && !qstat.empty;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = BIN_BITS'(q_item.read_bin);
        if (q_pop && (q_item.cmd == CMD_READ))
        begin
            rd_en = 1'b1;
        end
        else if ((state_reg == S_DEC) && do_inc)
        begin
            rd_en   = 1'b1;
            rd_addr = bin_idx[BIN_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= hist_mem[rd_addr];
            rd_valid_reg <= valid_bits_reg[rd_addr];
        end
        if (state_reg == S_INC)
        begin
            hist_mem[bin_reg] <= inc_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pcnt_reg       <= '0;
            valid_bits_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        unique case (q_item.cmd)
                            CMD_PAIR:
                            begin
                                if (q_item.new_center)
                                begin
                                    pcnt_reg <= '0;
                                end
                                state_reg <= S_SQ;
                            end
                            CMD_READ:
                            begin
                                state_reg <= S_RDCMD;
                            end
                            CMD_CLEAR:
                            begin
                                valid_bits_reg <= '0;
                                state_reg      <= S_OUT;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SQ:
                begin
                    if (sq_cnt_reg == 2'd3)
                    begin
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (bit_reg[0])
                    begin
                        state_reg <= S_BIN;
                    end
                end
                S_BIN:
                begin
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    if (below_reg && !slots_full)
                    begin
                        pcnt_reg <= pcnt_reg + 1'b1;
                    end
                    state_reg <= do_inc ? S_INC : S_OUT;
                end
                S_RDCMD:
                begin
                    state_reg <= S_OUT;
                end
                S_INC:
                begin
                    valid_bits_reg[bin_reg] <= 1'b1;
                    state_reg               <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    item_reg        <= q_item;
                    sq_cnt_reg      <= 2'd0;
                    v_reg           <= '0;
                    rdok_reg        <= read_ok;
                    res_dist_reg    <= '0;
                    res_counted_reg <= 1'b0;
                    res_hit_reg     <= '0;
                    res_oor_reg     <= 1'b0;
                    res_cnt_reg     <= '0;
                end
            end
            S_SQ:
            begin
                prod_reg   <= sq;
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
                if (sq_cnt_reg != 2'd0)
                begin
                    v_reg <= v_reg + SUM_BITS'(prod_reg);
                end
                if (sq_cnt_reg == 2'd3)
                begin
                    root_reg <= '0;
                    bit_reg  <= BIT_START;
                end
            end
            S_ROOT:
            begin
                if (ge)
                begin
                    v_reg    <= v_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            S_BIN:
            begin
                scaled_reg   <= SCALED_BITS'(root_w) * SCALED_BITS'(cfg.bin_scale);
                below_reg    <= (SCALED_BITS'(root_w) < SCALED_BITS'(cfg.cutoff));
                res_dist_reg <= DIST_BITS'(root_w);
            end
            S_DEC:
            begin
                bin_reg <= bin_idx[BIN_BITS-1:0];
                if (below_reg)
                begin
                    res_hit_reg <= bin_idx[HIT_BITS-1:0];
                    res_oor_reg <= slots_full || !bin_ok;
                end
            end
            S_RDCMD:
            begin
                res_cnt_reg <= rdok_reg ? inc_old : '0;
            end
            S_INC:
            begin
                res_counted_reg <= 1'b1;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_dist_reg    <= res_dist_reg;
                    out_counted_reg <= res_counted_reg;
                    out_hit_reg     <= res_hit_reg;
                    out_oor_reg     <= res_oor_reg;
                    out_cnt_reg     <= res_cnt_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign distance     = out_dist_reg;
    assign counted      = out_counted_reg;
    assign bin_hit      = out_hit_reg;
    assign out_of_range = out_oor_reg;
    assign bin_count    = out_cnt_reg;

    `PPHD_ASSERT_IMP(a_pcnt_cap, 1'b1, pcnt_reg <= PCNT_BITS'(MAX_PARTNERS), "partner count past limit")
    `PPHD_ASSERT_IMP(a_pop_idle, q_pop, state_reg == S_IDLE, "queue popped while busy")
    `PPHD_ASSERT_NXT(a_root_end, (state_reg == S_ROOT) && bit_reg[0], state_reg == S_BIN, "root did not finish")
    `PPHD_ASSERT_IMP(a_flag_excl, out_valid_reg, !(out_counted_reg && out_oor_reg), "counted and out of range")

endmodule

[hw/rtl/periodic_pair_distance_histogram_unit.sv]
// One word at a time is worked: a pair goes through the shared square unit, the 17-step
// iterative square root, binning and, when counted, the histogram update; a read goes through
// a histogram read, and a clear or an unused command goes straight to the output stage.
// A two-word queue lets input words be accepted while the back end is busy.
// Reset loads the default register values and clears all histogram bins at once.
module periodic_pair_distance_histogram_unit
    import pphd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                command,
    input  logic                      new_center,
    input  logic [15:0]               center_x,
    input  logic [15:0]               center_y,
    input  logic [15:0]               center_z,
    input  logic [15:0]               partner_x,
    input  logic [15:0]               partner_y,
    input  logic [15:0]               partner_z,
    input  logic [RBIN_BITS-1:0]      read_bin,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [DIST_BITS-1:0]      distance,
    output logic                      counted,
    output logic [HIT_BITS-1:0]       bin_hit,
    output logic                      out_of_range,
    output logic [CNT_BITS-1:0]       bin_count
);

    pphd_cfg_t   cfg_reg;
    pphd_qstat_t qstat;
    pphd_item_t  push_item;
    pphd_item_t  head;
    logic        push;
    logic        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_x       <= BOX_BITS'(2560);
            cfg_reg.box_y       <= BOX_BITS'(2560);
            cfg_reg.box_z       <= BOX_BITS'(2560);
            cfg_reg.cutoff      <= CUTOFF_BITS'(307);
            cfg_reg.bin_scale   <= SCALE_BITS'(65536);
            cfg_reg.bins_in_use <= BINUSE_BITS'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BOX_X:     cfg_reg.box_x       <= cfg_data[BOX_BITS-1:0];
                CFG_BOX_Y:     cfg_reg.box_y       <= cfg_data[BOX_BITS-1:0];
                CFG_BOX_Z:     cfg_reg.box_z       <= cfg_data[BOX_BITS-1:0];
                CFG_CUTOFF:    cfg_reg.cutoff      <= cfg_data[CUTOFF_BITS-1:0];
                CFG_BIN_SCALE: cfg_reg.bin_scale   <= cfg_data[SCALE_BITS-1:0];
                CFG_BINS_USED: cfg_reg.bins_in_use <= cfg_data[BINUSE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    pphd_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .new_center (new_center),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .partner_x  (partner_x),
        .partner_y  (partner_y),
        .partner_z  (partner_z),
        .read_bin   (read_bin),
        .cfg        (cfg_reg),
        .qstat      (qstat),
        .push       (push),
        .item       (push_item)
    );

    pphd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    pphd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_item       (head),
        .qstat        (qstat),
        .q_pop        (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .distance     (distance),
        .counted      (counted),
        .bin_hit      (bin_hit),
        .out_of_range (out_of_range),
        .bin_count    (bin_count)
    );

endmodule

[tb/tb_periodic_pair_distance_histogram_unit.sv]
module tb_periodic_pair_distance_histogram_unit;
    import pphd_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic        new_center;
        logic [15:0] cx, cy, cz;
        logic [15:0] px, py, pz;
        logic [7:0]  read_bin;
    } word_t;

    typedef struct {
        logic [17:0] distance;
        logic        counted;
        logic [7:0]  bin_hit;
        logic        out_of_range;
        logic [31:0] bin_count;
    } result_t;

    localparam int IDLE_LIMIT = 4000;
    localparam int NUM_BINS   = 256;
    localparam int SLOTS      = 4;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               command;
    logic                     new_center;
    logic [15:0]              center_x, center_y, center_z;
    logic [15:0]              partner_x, partner_y, partner_z;
    logic [RBIN_BITS-1:0]     read_bin;
    logic                     out_valid;
    logic                     out_stall;
    logic [DIST_BITS-1:0]     distance;
    logic                     counted;
    logic [HIT_BITS-1:0]      bin_hit;
    logic                     out_of_range;
    logic [CNT_BITS-1:0]      bin_count;

    logic [31:0] hist_model [NUM_BINS];
    int unsigned slots_used;
    logic [15:0] m_box_x, m_box_y, m_box_z;
    logic [17:0] m_cutoff;
    logic [23:0] m_scale;
    logic [8:0]  m_bins_used;

    result_t     expected_q[$];
    int          mismatches;
    int          words_sent;
    int          results_seen;
    int          pairs_counted;
    int          pairs_dropped;
    int          idle_cycles;
    int          hold_cycles;
    int          stall_mode;
    int          burst_left;
    bit          gaps_on;
    logic [15:0] cur_cx, cur_cy, cur_cz;

    periodic_pair_distance_histogram_unit u_dut (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint unsigned axis_gap(input logic [15:0] c, input logic [15:0] p,
                                                 input logic [15:0] box);
        longint unsigned mag;
        mag = (c >= p) ? longint'(c - p) : longint'(p - c);
        if (box != 0 && 2 * mag >= box)
            mag = (mag >= box) ? mag - box : box - mag;
        return mag;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
            begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    task automatic predict_word(input word_t w, output result_t r);
        longint unsigned ax, ay, az, pair_dist, bin, lim;
        r = '{default: '0};
        case (w.cmd)
            CMD_PAIR:
            begin
                if (w.new_center)
                    slots_used = 0;
                ax = axis_gap(w.cx, w.px, m_box_x);
                ay = axis_gap(w.cy, w.py, m_box_y);
                az = axis_gap(w.cz, w.pz, m_box_z);
                pair_dist = root_floor(ax * ax + ay * ay + az * az);
                r.distance = pair_dist[17:0];
                if (pair_dist < m_cutoff)
                begin
                    bin = (pair_dist * m_scale) >> 16;
                    r.bin_hit = bin[7:0];
                    lim = (m_bins_used > NUM_BINS) ? NUM_BINS : m_bins_used;
                    if (slots_used >= SLOTS)
                    begin
                        r.out_of_range = 1'b1;
                    end
                    else
                    begin
                        slots_used++;
                        if (bin < lim)
                        begin
                            if (hist_model[bin[7:0]] != 32'hFFFF_FFFF)
                                hist_model[bin[7:0]]++;
                            r.counted = 1'b1;
                        end
                        else
                        begin
                            r.out_of_range = 1'b1;
                        end
                    end
                end
            end
            CMD_READ:
                r.bin_count = hist_model[w.read_bin];
            CMD_CLEAR:
                foreach (hist_model[i])
                    hist_model[i] = '0;
            default:
                ;
        endcase
    endtask

    task automatic drain();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val[23:0];
        case (idx)
            CFG_BOX_X:     m_box_x = val[15:0];
            CFG_BOX_Y:     m_box_y = val[15:0];
            CFG_BOX_Z:     m_box_z = val[15:0];
            CFG_CUTOFF:    m_cutoff = val[17:0];
            CFG_BIN_SCALE: m_scale = val[23:0];
            CFG_BINS_USED: m_bins_used = val[8:0];
            default:       ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_config(input int unsigned bx, input int unsigned by, input int unsigned bz,
                              input int unsigned cut, input int unsigned scale,
                              input int unsigned used);
        drain();
        write_reg(CFG_BOX_X, bx);
        write_reg(CFG_BOX_Y, by);
        write_reg(CFG_BOX_Z, bz);
        write_reg(CFG_CUTOFF, cut);
        write_reg(CFG_BIN_SCALE, scale);
        write_reg(CFG_BINS_USED, used);
    endtask

    // Called at a negedge; returns at a negedge after the word is taken and any input gap.
    task automatic send_word(input word_t w);
        result_t r;
        command = w.cmd;
        new_center = w.new_center;
        center_x = w.cx;
        center_y = w.cy;
        center_z = w.cz;
        partner_x = w.px;
        partner_y = w.py;
        partner_z = w.pz;
        read_bin = w.read_bin;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_word(w, r);
        expected_q.push_back(r);
        words_sent++;
        @(negedge clk);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                burst_left = $urandom_range(1, 20);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    function automatic word_t pair_word(input logic nc, input logic [15:0] cx,
                                        input logic [15:0] cy, input logic [15:0] cz,
                                        input logic [15:0] px, input logic [15:0] py,
                                        input logic [15:0] pz);
        word_t w;
        w = '{cmd: CMD_PAIR, new_center: nc, cx: cx, cy: cy, cz: cz, px: px, py: py, pz: pz,
              read_bin: '0};
        return w;
    endfunction

    function automatic word_t other_word(input cmd_t c, input logic [7:0] rb);
        word_t w;
        w = '{cmd: c, new_center: 1'($urandom_range(0, 1)), cx: 16'($urandom),
              cy: 16'($urandom), cz: 16'($urandom), px: 16'($urandom), py: 16'($urandom),
              pz: 16'($urandom), read_bin: rb};
        return w;
    endfunction

    function automatic logic [15:0] near(input logic [15:0] c, input int spread);
        return c + 16'($urandom_range(0, 2 * spread) - spread);
    endfunction

    // Mostly centers with a run of nearby partners, plus reads, the odd clear and no-op words.
    task automatic send_random(input int n, input int spread);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
            begin
                logic nc;
                nc = ($urandom_range(0, 4) == 0);
                if (nc)
                begin
                    cur_cx = 16'($urandom);
                    cur_cy = 16'($urandom);
                    cur_cz = 16'($urandom);
                end
                if ($urandom_range(0, 9) < 2)
                    send_word(pair_word(nc, cur_cx, cur_cy, cur_cz, 16'($urandom),
                                        16'($urandom), 16'($urandom)));
                else
                    send_word(pair_word(nc, cur_cx, cur_cy, cur_cz, near(cur_cx, spread),
                                        near(cur_cy, spread), near(cur_cz, spread)));
            end
            else if (pick < 93)
            begin
                send_word(other_word(CMD_READ, ($urandom_range(0, 3) != 0) ?
                                     8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255))));
            end
            else if (pick < 95)
            begin
                send_word(other_word(CMD_CLEAR, 8'($urandom)));
            end
            else
            begin
                send_word(other_word(CMD_NOP, 8'($urandom)));
            end
        end
        in_valid = 1'b0;
    endtask

    task automatic test_directed();
        send_word(pair_word(1'b1, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000));
        send_word(pair_word(1'b0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_word(pair_word(1'b0, 16'hFFFF, 16'd0, 16'h8000, 16'd0, 16'hFFFF, 16'h7FFF));
        send_word(pair_word(1'b0, 16'd1280, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_word(pair_word(1'b0, 16'd100, 16'd100, 16'd100, 16'd150, 16'd50, 16'd100));
        send_word(pair_word(1'b0, 16'd100, 16'd100, 16'd100, 16'd300, 16'd100, 16'd100));
        send_word(pair_word(1'b1, 16'd500, 16'd500, 16'd500, 16'd501, 16'd500, 16'd500));
        send_word(pair_word(1'b0, 16'd500, 16'd500, 16'd500, 16'd510, 16'd500, 16'd500));
        send_word(pair_word(1'b0, 16'd500, 16'd500, 16'd500, 16'd500, 16'd520, 16'd500));
        send_word(pair_word(1'b0, 16'd500, 16'd500, 16'd500, 16'd500, 16'd500, 16'd530));
        send_word(pair_word(1'b0, 16'd500, 16'd500, 16'd500, 16'd540, 16'd500, 16'd500));
        send_word(pair_word(1'b0, 16'd500, 16'd500, 16'd500, 16'd500, 16'd500, 16'd500));
        send_word(other_word(CMD_READ, 8'd1));
        send_word(other_word(CMD_READ, 8'd0));
        send_word(other_word(CMD_READ, 8'd255));
        send_word(other_word(CMD_NOP, 8'd0));
        send_word(other_word(CMD_CLEAR, 8'd0));
        send_word(other_word(CMD_READ, 8'd1));
        send_word(pair_word(1'b0, 16'd500, 16'd500, 16'd500, 16'd600, 16'd500, 16'd500));
        in_valid = 1'b0;
        set_config(2560, 2560, 2560, 307, 65536, 20);
        send_word(pair_word(1'b1, 16'd500, 16'd500, 16'd500, 16'd530, 16'd500, 16'd500));
        send_word(pair_word(1'b0, 16'd500, 16'd500, 16'd500, 16'd510, 16'd500, 16'd500));
        send_word(other_word(CMD_READ, 8'd10));
        in_valid = 1'b0;
    endtask

    task automatic test_register_sweep();
        set_config(1, 65535, 0, 262143, 16777215, 0);
        send_random(100, 3000);
        set_config(65535, 1, 2560, 0, 0, 1);
        send_random(60, 400);
        set_config(3000, 2000, 65535, 262143, 0, 511);
        send_random(100, 2000);
        set_config(256, 512, 1024, 600, 16777215, 256);
        send_random(100, 500);
        set_config(2560, 2560, 2560, 2000, 2048, 1);
        send_random(100, 1500);
        set_config(2560, 2560, 2560, 307, 65536, 256);
    endtask

    task automatic test_random_traffic();
        set_config(2560, 2560, 2560, 400, 40000, 200);
        send_random(800, 300);
    endtask

    task automatic test_backpressure();
        drain();
        gaps_on = 1'b0;
        hold_cycles = 400;
        send_random(25, 300);
        gaps_on = 1'b1;
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall = 1'b1;
            hold_cycles--;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0:       out_stall = 1'b0;
                1:       out_stall = ($urandom_range(0, 9) < 3);
                default: out_stall = ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    always @(posedge clk)
    begin
        result_t e;
        if (out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: distance %0d", distance);
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.counted)
                    pairs_counted++;
                if (e.out_of_range)
                    pairs_dropped++;
                if (distance !== e.distance || counted !== e.counted ||
                    bin_hit !== e.bin_hit || out_of_range !== e.out_of_range ||
                    bin_count !== e.bin_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                 e.distance, e.counted, e.bin_hit, e.out_of_range, e.bin_count,
                                 distance, counted, bin_hit, out_of_range, bin_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout with %0d results outstanding", expected_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = '0;
        new_center = 1'b0;
        center_x = '0;
        center_y = '0;
        center_z = '0;
        partner_x = '0;
        partner_y = '0;
        partner_z = '0;
        read_bin = '0;
        out_stall = 1'b0;
        stall_mode = 0;
        hold_cycles = 0;
        mismatches = 0;
        words_sent = 0;
        results_seen = 0;
        pairs_counted = 0;
        pairs_dropped = 0;
        idle_cycles = 0;
        burst_left = 8;
        gaps_on = 1'b1;
        cur_cx = 16'd1000;
        cur_cy = 16'd1000;
        cur_cz = 16'd1000;
        foreach (hist_model[i])
            hist_model[i] = '0;
        slots_used = 0;
        m_box_x = 16'd2560;
        m_box_y = 16'd2560;
        m_box_z = 16'd2560;
        m_cutoff = 18'd307;
        m_scale = 24'd65536;
        m_bins_used = 9'd256;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(negedge clk);
        test_directed();
        test_register_sweep();
        test_backpressure();
        test_random_traffic();
        drain();
        $display("Sent %0d words, checked %0d results: %0d pairs binned, %0d dropped.",
                 words_sent, results_seen, pairs_counted, pairs_dropped);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
